/* rtl/gbcal_pkg.sv */
// shared types and constants for the gyro bias calibrate and subtract block
package gbcal_pkg;

	localparam int RATE_W = 16;
	localparam int CNT_W  = 8;
	localparam int AXES   = 3;

	// calibration phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SKIP = 2'd1;
	localparam logic [1:0] PH_AVG  = 2'd2;

	// per-word commands from the phase sequencer to the bias unit
	typedef struct packed {
		logic clr;
		logic acc;
		logic load;
	} ctl_t;

	typedef logic signed [RATE_W-1:0] rate_t;

endpackage

/* rtl/gbcal_ctrl.sv */
// calibration phase sequencer: skip count, average count, bias load strobe
module gbcal_ctrl #(
	parameter int SKIP_SAMPLES    = 200,
	parameter int AVERAGE_SAMPLES = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               start,
	output gbcal_pkg::ctl_t    ctl,
	output logic               calibrating
);

	logic [1:0]                  phase_q, phase_d;
	logic [gbcal_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;

	assign cnt_inc = cnt_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		ctl.clr  = 1'b0;
		ctl.acc  = 1'b0;
		ctl.load = 1'b0;
		if (start) begin
			phase_d = (SKIP_SAMPLES == 0) ? gbcal_pkg::PH_AVG : gbcal_pkg::PH_SKIP;
			cnt_d   = '0;
			ctl.clr = 1'b1;
		end else begin
			case (phase_q)
				gbcal_pkg::PH_SKIP: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= gbcal_pkg::CNT_W'(SKIP_SAMPLES)) begin
						phase_d = gbcal_pkg::PH_AVG;
						cnt_d   = '0;
					end
				end
				gbcal_pkg::PH_AVG: begin
					ctl.acc = 1'b1;
					cnt_d   = cnt_inc;
					if (cnt_inc >= gbcal_pkg::CNT_W'(AVERAGE_SAMPLES)) begin
						ctl.load = 1'b1;
						phase_d  = gbcal_pkg::PH_IDLE;
						cnt_d    = '0;
					end
				end
				default: begin
					phase_d = gbcal_pkg::PH_IDLE;
				end
			endcase
		end
	end

	assign calibrating = (phase_d == gbcal_pkg::PH_SKIP) || (phase_d == gbcal_pkg::PH_AVG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gbcal_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* rtl/gbcal_bias.sv */
// per-axis raw sums, constant-divisor mean and stored bias registers
module gbcal_bias #(
	parameter int AVERAGE_SAMPLES = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  gbcal_pkg::ctl_t  ctl,
	input  gbcal_pkg::rate_t raw  [gbcal_pkg::AXES],
	output gbcal_pkg::rate_t bias [gbcal_pkg::AXES]
);

	localparam int L_W    = $clog2(AVERAGE_SAMPLES);
	localparam int MAG_W  = gbcal_pkg::RATE_W + L_W;
	localparam int SUM_W  = MAG_W + 1;
	localparam int SHIFT  = MAG_W + L_W;
	localparam int M_W    = MAG_W + 2;
	localparam int PROD_W = MAG_W + M_W;
	// ceil(2^SHIFT / N): exact floor division for any magnitude below 2^MAG_W
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << SHIFT) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES));

	logic signed [SUM_W-1:0] sum_q [gbcal_pkg::AXES];

	for (genvar i = 0; i < gbcal_pkg::AXES; i++) begin : g_axis
		logic signed [SUM_W-1:0]  total;
		logic signed [SUM_W-1:0]  total_neg;
		logic                     neg;
		logic [MAG_W-1:0]         mag;
		logic [PROD_W-1:0]        prod;
		logic [gbcal_pkg::RATE_W-1:0] quo;
		logic [gbcal_pkg::RATE_W-1:0] mean;

		assign total     = sum_q[i] + SUM_W'(raw[i]);
		assign total_neg = -total;
		assign neg       = total[SUM_W-1];
		assign mag       = neg ? total_neg[MAG_W-1:0] : total[MAG_W-1:0];
		assign prod      = PROD_W'(mag) * PROD_W'(RECIP);
		assign quo       = prod[SHIFT +: gbcal_pkg::RATE_W];
		// truncation toward zero: divide the magnitude, restore the sign
		assign mean      = neg ? (~quo + 1'b1) : quo;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q[i] <= '0;
				bias[i]  <= '0;
			end else if (accept) begin
				if (ctl.clr) begin
					sum_q[i] <= '0;
				end else if (ctl.acc) begin
					sum_q[i] <= total;
				end
				if (ctl.load) begin
					bias[i] <= mean;
				end
			end
		end
	end

endmodule

/* rtl/gyro_bias_calibrate_subtract.sv */
// top level: gyro bias calibration and per-axis bias subtraction
//
// input stream: s_axis_tdata carries one three-axis gyro word (x, y, z signed
// 16 bit); s_axis_tuser is high for a start-calibration word, whose data is
// ignored. output stream: one word per input word, the sample minus the
// stored per-axis bias wrapped to 16 bits (zero for a start word), with
// tuser flags for calibration in progress and for the word that loaded new
// biases.
// a start word clears the running sums, then SKIP_SAMPLES samples are
// dropped from the average and the next AVERAGE_SAMPLES raw samples are
// summed; the last of them loads sum / AVERAGE_SAMPLES (toward zero) into the
// bias registers, used from the following word on. every word is still
// passed through during calibration, corrected with the old biases.
// an accepted word is registered in the output register; one word is
// accepted per cycle unless stalled, set by the single output register stage.
// reset clears phase, count, sums and biases to zero and empties the output.
// when the receiver stalls the output word holds and s_axis_tready drops
// until it is taken; a word is accepted in the same cycle the held one leaves.
module gyro_bias_calibrate_subtract #(
	parameter int SKIP_SAMPLES    = 200,
	parameter int AVERAGE_SAMPLES = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // rate_in_x, rate_in_y, rate_in_z
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // rate_out_x, rate_out_y, rate_out_z
	output logic [1:0]  m_axis_tuser   // calibrating, bias_updated
);

	logic             accept;
	logic             start;
	gbcal_pkg::ctl_t  ctl;
	logic             calibrating;
	gbcal_pkg::rate_t raw  [gbcal_pkg::AXES];
	gbcal_pkg::rate_t bias [gbcal_pkg::AXES];
	gbcal_pkg::rate_t corr [gbcal_pkg::AXES];

	// output register empty or being drained this cycle
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start         = s_axis_tuser;

	for (genvar i = 0; i < gbcal_pkg::AXES; i++) begin : g_axis
		assign raw[i]  = s_axis_tdata[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W];
		// wrapping subtract with the bias held before this word
		assign corr[i] = start ? '0 : (raw[i] - bias[i]);
	end

	gbcal_ctrl #(
		.SKIP_SAMPLES    (SKIP_SAMPLES),
		.AVERAGE_SAMPLES (AVERAGE_SAMPLES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.start       (start),
		.ctl         (ctl),
		.calibrating (calibrating)
	);

	gbcal_bias #(
		.AVERAGE_SAMPLES (AVERAGE_SAMPLES)
	) u_bias (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ctl    (ctl),
		.raw    (raw),
		.bias   (bias)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	// output payload, loaded only with an accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			m_axis_tdata <= {corr[2], corr[1], corr[0]};
			m_axis_tuser <= {ctl.load, calibrating};
		end
	end

endmodule

/* rtl/gbcal_chk.sv */
// port-level checks for the gyro bias block, bound to the top level
module gbcal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// no word taken while a full output register is stalled
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted into stalled output");

	// start word gives a zero word flagged as calibrating
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
			m_axis_tvalid && (m_axis_tdata == 48'd0) && m_axis_tuser[0] && !m_axis_tuser[1])
		else $error("start word result wrong");

	// bias load ends calibration
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("bias update flagged while still calibrating");

	// every accepted word shows up at the output the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted word did not reach output");

endmodule

bind gyro_bias_calibrate_subtract gbcal_chk u_gbcal_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/gyro_bias_calibrate_subtract_tb.sv */
// self-checking testbench for the gyro bias calibrate and subtract block
module gyro_bias_calibrate_subtract_tb;

	// block configuration, passed down to the instance so both sides agree
	localparam int SKIP_WORDS  = 200;
	localparam int AVG_WORDS   = 50;
	localparam int ITEM_TARGET = 450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORD_W      = gbcal_pkg::AXES * gbcal_pkg::RATE_W;

	// one expected output word; rate[0] is x, matching the tdata order
	typedef struct packed {
		logic                                                  bias_updated;
		logic                                                  calibrating;
		logic [gbcal_pkg::AXES-1:0][gbcal_pkg::RATE_W-1:0]     rate;
	} gyro_word_t;

	// tracks phase, count, sums and biases the way the block should, and
	// holds the output words still due
	class gyro_cal_tracker;
		logic [1:0]   phase;
		int           count;
		int           sum [gbcal_pkg::AXES];
		int           bias [gbcal_pkg::AXES];
		gyro_word_t   due_words [$];
		int           errors;

		function new();
			phase  = gbcal_pkg::PH_IDLE;
			count  = 0;
			errors = 0;
			for (int i = 0; i < gbcal_pkg::AXES; i++) begin
				sum[i]  = 0;
				bias[i] = 0;
			end
		endfunction

		// predict the output word caused by one accepted input word
		function void accept_word(logic start, logic [WORD_W-1:0] data);
			gyro_word_t       w;
			gbcal_pkg::rate_t raw;
			w = '0;
			if (start) begin
				// start or restart: sums cleared, stored biases kept
				phase = (SKIP_WORDS == 0) ? gbcal_pkg::PH_AVG : gbcal_pkg::PH_SKIP;
				count = 0;
				for (int i = 0; i < gbcal_pkg::AXES; i++)
					sum[i] = 0;
				w.calibrating = 1'b1;
			end else begin
				// output always uses the biases held before this word
				for (int i = 0; i < gbcal_pkg::AXES; i++) begin
					raw = gbcal_pkg::rate_t'(data[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W]);
					w.rate[i] = gbcal_pkg::rate_t'(int'(raw) - bias[i]);
					if (phase == gbcal_pkg::PH_AVG)
						sum[i] += int'(raw);
				end
				case (phase)
					gbcal_pkg::PH_SKIP: begin
						count = (count + 1) & 255;
						if (count >= SKIP_WORDS) begin
							phase = gbcal_pkg::PH_AVG;
							count = 0;
						end
					end
					gbcal_pkg::PH_AVG: begin
						count = (count + 1) & 255;
						if (count >= AVG_WORDS) begin
							// signed int division truncates toward zero
							for (int i = 0; i < gbcal_pkg::AXES; i++)
								bias[i] = sum[i] / AVG_WORDS;
							phase = gbcal_pkg::PH_IDLE;
							count = 0;
							w.bias_updated = 1'b1;
						end
					end
					default: phase = gbcal_pkg::PH_IDLE;
				endcase
				w.calibrating = (phase == gbcal_pkg::PH_SKIP || phase == gbcal_pkg::PH_AVG);
			end
			due_words.push_back(w);
		endfunction

		function void complain(string what, longint want, longint got);
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		endfunction

		// compare one delivered word, field by field, with the oldest prediction
		function void check_word(logic [WORD_W-1:0] data, logic [1:0] flags);
			gyro_word_t       want;
			gbcal_pkg::rate_t got;
			if (due_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("word with nothing due: data %h flags %b", data, flags);
				return;
			end
			want = due_words.pop_front();
			for (int i = 0; i < gbcal_pkg::AXES; i++) begin
				got = gbcal_pkg::rate_t'(data[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W]);
				if (got !== gbcal_pkg::rate_t'(want.rate[i]))
					complain($sformatf("rate_out axis %0d", i),
						gbcal_pkg::rate_t'(want.rate[i]), got);
			end
			if (flags[0] !== want.calibrating)
				complain("calibrating", want.calibrating, flags[0]);
			if (flags[1] !== want.bias_updated)
				complain("bias_updated", want.bias_updated, flags[1]);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [WORD_W-1:0]   s_axis_tdata;   // rate_in_x, rate_in_y, rate_in_z
	logic                s_axis_tuser;   // kind
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [WORD_W-1:0]   m_axis_tdata;   // rate_out_x, rate_out_y, rate_out_z
	logic [1:0]          m_axis_tuser;   // calibrating, bias_updated

	gyro_cal_tracker     tracker;
	int                  words_sent = 0;
	int                  cycles = 0;
	bit                  src_lazy = 1'b1;
	bit                  sink_lazy = 1'b0;

	gyro_bias_calibrate_subtract #(
		.SKIP_SAMPLES    (SKIP_WORDS),
		.AVERAGE_SAMPLES (AVG_WORDS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// both handshakes sampled at the edge, before any flop updates;
	// check first so a word leaving and one entering on the same edge stay ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				tracker.accept_word(s_axis_tuser, s_axis_tdata);
		end
	end

	// receiver: random stall before each word, with stretches of no stall
	initial begin
		int gap;
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_lazy = !sink_lazy;
			gap = sink_lazy ? int'($urandom_range(0, 19)) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	function automatic logic [WORD_W-1:0] pack_rates(int x, int y, int z);
		return {gbcal_pkg::rate_t'(z), gbcal_pkg::rate_t'(y), gbcal_pkg::rate_t'(x)};
	endfunction

	// sender: random gap, then hold the word until it is taken;
	// valid stays high across back-to-back words
	task automatic send_word(logic kind, logic [WORD_W-1:0] rates);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_lazy = !src_lazy;
		gap = src_lazy ? int'($urandom_range(0, 19)) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rates;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	// start word then a sample stream; a complete run goes past the bias load
	// so the new biases show up, an aborted one ends early (next start restarts)
	task automatic run_calibration(bit complete);
		int                  n;
		int                  style;
		int                  ctr [gbcal_pkg::AXES];
		logic [WORD_W-1:0]   d;
		style = $urandom_range(0, 3);
		for (int i = 0; i < gbcal_pkg::AXES; i++) begin
			ctr[i] = int'($urandom_range(0, 65535)) - 32768;
			// extreme style: every sample pinned at full scale
			if (style == 3)
				ctr[i] = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
		end
		n = complete ? SKIP_WORDS + AVG_WORDS + int'($urandom_range(1, 30))
			: int'($urandom_range(1, SKIP_WORDS + AVG_WORDS - 1));
		// keep the total close to the target word count
		if (n > ITEM_TARGET - words_sent - 1)
			n = ITEM_TARGET - words_sent - 1;
		send_word(1'b1, pack_rates($urandom, $urandom, $urandom));
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < gbcal_pkg::AXES; i++) begin
				case (style)
					0: d[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W] =
						gbcal_pkg::rate_t'($urandom);
					1: d[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W] =
						gbcal_pkg::rate_t'(ctr[i] + int'($urandom_range(0, 256)) - 128);
					2: d[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W] =
						gbcal_pkg::rate_t'(ctr[i] + int'($urandom_range(0, 8191)) - 4096);
					default: d[i*gbcal_pkg::RATE_W +: gbcal_pkg::RATE_W] =
						gbcal_pkg::rate_t'(ctr[i]);
				endcase
			end
			send_word(1'b0, d);
		end
	endtask

	// unstructured traffic, mostly samples with the odd start mixed in
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 20);
		if (n > ITEM_TARGET - words_sent)
			n = ITEM_TARGET - words_sent;
		for (int k = 0; k < n; k++)
			send_word($urandom_range(0, 7) == 0, pack_rates($urandom, $urandom, $urandom));
	endtask

	initial begin
		bit first;
		tracker = new();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		arst_n        <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// zero bias: full-scale and bit-pattern samples pass straight through
		send_word(1'b0, pack_rates(0, 0, 0));
		send_word(1'b0, pack_rates(32767, -32768, -1));
		send_word(1'b0, pack_rates(-32768, 32767, 1));
		send_word(1'b0, pack_rates('h5555, 'haaaa, 'h0f0f));
		// start word with junk data, then samples returned while skipping
		send_word(1'b1, pack_rates(32767, -1, -32768));
		send_word(1'b0, pack_rates(100, -100, 0));
		send_word(1'b0, pack_rates(-32768, -32768, 32767));
		// restart while calibrating, and two starts back to back
		send_word(1'b1, pack_rates(0, 0, 0));
		send_word(1'b0, pack_rates(1, 2, 3));
		send_word(1'b1, pack_rates(-1, -1, -1));
		send_word(1'b1, pack_rates(0, 0, 0));
		send_word(1'b0, pack_rates(-5, 7, -32768));

		// first random run always completes so the bias load is reached
		first = 1'b1;
		while (words_sent < ITEM_TARGET) begin
			if (first || $urandom_range(0, 9) < 7)
				run_calibration(first || $urandom_range(0, 2) != 0);
			else
				noise_burst();
			first = 1'b0;
		end
		s_axis_tvalid <= 1'b0;

		// drain, then a few idle cycles to catch stray words
		while (tracker.due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.errors == 0 && tracker.due_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/gbcal_pkg.sv
rtl/gbcal_ctrl.sv
rtl/gbcal_bias.sv
rtl/gyro_bias_calibrate_subtract.sv
rtl/gbcal_chk.sv
tb/sv/gyro_bias_calibrate_subtract_tb.sv
